// ===== design/sha512_pkg.sv =====
`default_nettype none
package sha512_pkg;

    localparam int WordWidth = 64;
    localparam int BlockWords = 16;
    localparam int Rounds = 80;

    typedef enum logic [1:0] {
        VAR_SHA512 = 2'd0,
        VAR_SHA384 = 2'd1,
        VAR_SHA512_256 = 2'd2,
        VAR_UNUSED = 2'd3
    } variant_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PACK,
        ST_PAD,
        ST_ROUNDS,
        ST_FOLD,
        ST_EMIT
    } state_t;

    localparam logic [6:0] LenFieldPos = 7'd112;
    localparam logic [7:0] PadByte = 8'h80;

    function automatic logic [63:0] round_k(input logic [6:0] i);
        logic [63:0] r;
        begin
            unique case (i)
                7'd0: r = 64'h428A2F98D728AE22; 7'd1: r = 64'h7137449123EF65CD;
                7'd2: r = 64'hB5C0FBCFEC4D3B2F; 7'd3: r = 64'hE9B5DBA58189DBBC;
                7'd4: r = 64'h3956C25BF348B538; 7'd5: r = 64'h59F111F1B605D019;
                7'd6: r = 64'h923F82A4AF194F9B; 7'd7: r = 64'hAB1C5ED5DA6D8118;
                7'd8: r = 64'hD807AA98A3030242; 7'd9: r = 64'h12835B0145706FBE;
                7'd10: r = 64'h243185BE4EE4B28C; 7'd11: r = 64'h550C7DC3D5FFB4E2;
                7'd12: r = 64'h72BE5D74F27B896F; 7'd13: r = 64'h80DEB1FE3B1696B1;
                7'd14: r = 64'h9BDC06A725C71235; 7'd15: r = 64'hC19BF174CF692694;
                7'd16: r = 64'hE49B69C19EF14AD2; 7'd17: r = 64'hEFBE4786384F25E3;
                7'd18: r = 64'h0FC19DC68B8CD5B5; 7'd19: r = 64'h240CA1CC77AC9C65;
                7'd20: r = 64'h2DE92C6F592B0275; 7'd21: r = 64'h4A7484AA6EA6E483;
                7'd22: r = 64'h5CB0A9DCBD41FBD4; 7'd23: r = 64'h76F988DA831153B5;
                7'd24: r = 64'h983E5152EE66DFAB; 7'd25: r = 64'hA831C66D2DB43210;
                7'd26: r = 64'hB00327C898FB213F; 7'd27: r = 64'hBF597FC7BEEF0EE4;
                7'd28: r = 64'hC6E00BF33DA88FC2; 7'd29: r = 64'hD5A79147930AA725;
                7'd30: r = 64'h06CA6351E003826F; 7'd31: r = 64'h142929670A0E6E70;
                7'd32: r = 64'h27B70A8546D22FFC; 7'd33: r = 64'h2E1B21385C26C926;
                7'd34: r = 64'h4D2C6DFC5AC42AED; 7'd35: r = 64'h53380D139D95B3DF;
                7'd36: r = 64'h650A73548BAF63DE; 7'd37: r = 64'h766A0ABB3C77B2A8;
                7'd38: r = 64'h81C2C92E47EDAEE6; 7'd39: r = 64'h92722C851482353B;
                7'd40: r = 64'hA2BFE8A14CF10364; 7'd41: r = 64'hA81A664BBC423001;
                7'd42: r = 64'hC24B8B70D0F89791; 7'd43: r = 64'hC76C51A30654BE30;
                7'd44: r = 64'hD192E819D6EF5218; 7'd45: r = 64'hD69906245565A910;
                7'd46: r = 64'hF40E35855771202A; 7'd47: r = 64'h106AA07032BBD1B8;
                7'd48: r = 64'h19A4C116B8D2D0C8; 7'd49: r = 64'h1E376C085141AB53;
                7'd50: r = 64'h2748774CDF8EEB99; 7'd51: r = 64'h34B0BCB5E19B48A8;
                7'd52: r = 64'h391C0CB3C5C95A63; 7'd53: r = 64'h4ED8AA4AE3418ACB;
                7'd54: r = 64'h5B9CCA4F7763E373; 7'd55: r = 64'h682E6FF3D6B2B8A3;
                7'd56: r = 64'h748F82EE5DEFB2FC; 7'd57: r = 64'h78A5636F43172F60;
                7'd58: r = 64'h84C87814A1F0AB72; 7'd59: r = 64'h8CC702081A6439EC;
                7'd60: r = 64'h90BEFFFA23631E28; 7'd61: r = 64'hA4506CEBDE82BDE9;
                7'd62: r = 64'hBEF9A3F7B2C67915; 7'd63: r = 64'hC67178F2E372532B;
                7'd64: r = 64'hCA273ECEEA26619C; 7'd65: r = 64'hD186B8C721C0C207;
                7'd66: r = 64'hEADA7DD6CDE0EB1E; 7'd67: r = 64'hF57D4F7FEE6ED178;
                7'd68: r = 64'h06F067AA72176FBA; 7'd69: r = 64'h0A637DC5A2C898A6;
                7'd70: r = 64'h113F9804BEF90DAE; 7'd71: r = 64'h1B710B35131C471B;
                7'd72: r = 64'h28DB77F523047D84; 7'd73: r = 64'h32CAAB7B40C72493;
                7'd74: r = 64'h3C9EBE0A15C9BEBC; 7'd75: r = 64'h431D67C49C100D4C;
                7'd76: r = 64'h4CC5D4BECB3E42B6; 7'd77: r = 64'h597F299CFC657E2A;
                7'd78: r = 64'h5FCB6FAB3AD6FAEC; 7'd79: r = 64'h6C44198C4A475817;
                default: r = 64'h0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [63:0] start_vector(input logic [1:0] v, input logic [2:0] i);
        logic [63:0] r;
        begin
            unique case ({(v == VAR_SHA384 || v == VAR_SHA512_256) ? v : 2'd0, i})
                5'b00_000: r = 64'h6A09E667F3BCC908; 5'b00_001: r = 64'hBB67AE8584CAA73B;
                5'b00_010: r = 64'h3C6EF372FE94F82B; 5'b00_011: r = 64'hA54FF53A5F1D36F1;
                5'b00_100: r = 64'h510E527FADE682D1; 5'b00_101: r = 64'h9B05688C2B3E6C1F;
                5'b00_110: r = 64'h1F83D9ABFB41BD6B; 5'b00_111: r = 64'h5BE0CD19137E2179;
                5'b01_000: r = 64'hCBBB9D5DC1059ED8; 5'b01_001: r = 64'h629A292A367CD507;
                5'b01_010: r = 64'h9159015A3070DD17; 5'b01_011: r = 64'h152FECD8F70E5939;
                5'b01_100: r = 64'h67332667FFC00B31; 5'b01_101: r = 64'h8EB44A8768581511;
                5'b01_110: r = 64'hDB0C2E0D64F98FA7; 5'b01_111: r = 64'h47B5481DBEFA4FA4;
                5'b10_000: r = 64'h22312194FC2BF72C; 5'b10_001: r = 64'h9F555FA3C84C64C2;
                5'b10_010: r = 64'h2393B86B6F53B151; 5'b10_011: r = 64'h963877195940EABD;
                5'b10_100: r = 64'h96283EE2A88EFFE3; 5'b10_101: r = 64'hBE5E1E2553863992;
                5'b10_110: r = 64'h2B0199FC2C85B8AA; 5'b10_111: r = 64'h0EB72DDC81C52CA2;
                default: r = 64'h0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

endpackage
`default_nettype wire

// ===== design/sha512_round.sv =====
`default_nettype none
// one sha-512 round plus message schedule step, shared over all 80 rounds
module sha512_round
    import sha512_pkg::*;
(
    input  wire logic [63:0] vars [8],
    input  wire logic [63:0] sched [16],
    input  wire logic [6:0]  round,
    output logic [63:0] vars_out [8],
    output logic [63:0] w_out
);
    logic [63:0] p, q, s0, s1, wi, t1, t2;

    always_comb
    begin
        p = sched[1];
        q = sched[14];
        s0 = rotr(p, 1) ^ rotr(p, 8) ^ (p >> 7);
        s1 = rotr(q, 19) ^ rotr(q, 61) ^ (q >> 6);
        // schedule window holds w[i-16..i-1] from round 16 on; early rounds read raw words
        if (round < 7'd16)
            wi = sched[0];
        else
            wi = sched[0] + s0 + sched[9] + s1;
        t1 = vars[7] + (rotr(vars[4], 14) ^ rotr(vars[4], 18) ^ rotr(vars[4], 41))
           + ((vars[4] & vars[5]) ^ (~vars[4] & vars[6])) + round_k(round) + wi;
        t2 = (rotr(vars[0], 28) ^ rotr(vars[0], 34) ^ rotr(vars[0], 39))
           + ((vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]));
        vars_out[7] = vars[6];
        vars_out[6] = vars[5];
        vars_out[5] = vars[4];
        vars_out[4] = vars[3] + t1;
        vars_out[3] = vars[2];
        vars_out[2] = vars[1];
        vars_out[1] = vars[0];
        vars_out[0] = t1 + t2;
        w_out = wi;
    end
endmodule
`default_nettype wire

// ===== design/sha512_family_hash_engine.sv =====
`default_nettype none
// the byte packer stores a word one byte at a time; each full block is compressed by
//   the shared round unit, one round per cycle, and the last word may need up to 2 compressions
// a new word is taken only when idle; in_stall is high while a word is packed, padded or
//   compressed or the digest is emitted; digest words go out one a cycle while out_stall is low
// reset: sha-512 selected, its initial vector loaded, byte count and block fill cleared
module sha512_family_hash_engine
    import sha512_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] message_word,
    input  wire logic [3:0]  valid_bytes,
    input  wire logic        last_in,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);
    state_t state_reg, state_next;
    logic [1:0] variant_reg;
    logic [63:0] hash_reg [8];
    logic [63:0] vars_reg [8];
    logic [63:0] sched_reg [16];
    logic [6:0] fill_reg;
    logic [63:0] len_lo_reg, len_hi_reg;
    logic [63:0] word_reg;
    logic [3:0] nbytes_reg;
    logic last_reg, padded_reg, after_reg;
    logic [6:0] round_reg;
    logic [2:0] idx_reg;
    logic [63:0] vars_out [8];
    logic [63:0] w_out;
    logic cfg_wr, full, in_acc, out_acc;
    logic [2:0] nwords_m1;

    sha512_round u_round (
        .vars(vars_reg), .sched(sched_reg), .round(round_reg),
        .vars_out(vars_out), .w_out(w_out)
    );

    assign pready = 1'b1;
    assign prdata = {30'd0, variant_reg};
    assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc = in_valid && !in_stall;
    assign out_valid = (state_reg == ST_EMIT);
    assign out_acc = out_valid && !out_stall;
    assign digest_word = hash_reg[idx_reg];
    assign word_index = idx_reg;
    assign nwords_m1 = (variant_reg == VAR_SHA384) ? 3'd5 :
                       (variant_reg == VAR_SHA512_256) ? 3'd3 : 3'd7;
    assign last_word = (idx_reg == nwords_m1);
    assign full = (fill_reg == 7'd127);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_acc) state_next = ST_PACK;
            ST_PACK:
            begin
                if (nbytes_reg != 4'd0 && full) state_next = ST_ROUNDS;
                else if (nbytes_reg == 4'd0) state_next = last_reg ? ST_PAD : ST_IDLE;
            end
            ST_PAD:
            begin
                if (fill_reg == LenFieldPos && padded_reg) state_next = ST_ROUNDS;
                else if (full) state_next = ST_ROUNDS;
            end
            ST_ROUNDS: if (round_reg == 7'(Rounds - 1)) state_next = ST_FOLD;
            ST_FOLD:
            begin
                if (after_reg) state_next = ST_EMIT;
                else if (nbytes_reg != 4'd0) state_next = ST_PACK;
                else if (last_reg) state_next = ST_PAD;
                else state_next = ST_IDLE;
            end
            ST_EMIT:   if (out_acc && last_word) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else if (cfg_wr)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg <= VAR_SHA512;
            fill_reg <= 7'd0;
            len_lo_reg <= 64'd0;
            len_hi_reg <= 64'd0;
            padded_reg <= 1'b0;
            after_reg <= 1'b0;
            round_reg <= 7'd0;
            idx_reg <= 3'd0;
            nbytes_reg <= 4'd0;
            last_reg <= 1'b0;
            for (int i = 0; i < 8; i++) hash_reg[i] <= start_vector(2'd0, 3'(i));
        end
        else if (cfg_wr)
        begin
            variant_reg <= pwdata[1:0];
            fill_reg <= 7'd0;
            len_lo_reg <= 64'd0;
            len_hi_reg <= 64'd0;
            for (int i = 0; i < 8; i++) hash_reg[i] <= start_vector(pwdata[1:0], 3'(i));
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                if (in_acc)
                begin
                    word_reg <= message_word;
                    nbytes_reg <= (valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
                    last_reg <= last_in;
                    padded_reg <= 1'b0;
                    after_reg <= 1'b0;
                    {len_hi_reg, len_lo_reg} <= {len_hi_reg, len_lo_reg}
                        + 128'((valid_bytes > 4'd8) ? 4'd8 : valid_bytes);
                end
                ST_PACK:
                if (nbytes_reg != 4'd0)
                begin
                    sched_reg[fill_reg[6:3]][8*(7-fill_reg[2:0]) +: 8] <= word_reg[63:56];
                    word_reg <= {word_reg[55:0], 8'd0};
                    nbytes_reg <= nbytes_reg - 4'd1;
                    fill_reg <= fill_reg + 7'd1;
                    if (full)
                    begin
                        round_reg <= 7'd0;
                        for (int i = 0; i < 8; i++) vars_reg[i] <= hash_reg[i];
                    end
                end
                ST_PAD:
                begin
                    if (fill_reg == LenFieldPos && padded_reg)
                    begin
                        sched_reg[14] <= {len_hi_reg[60:0], len_lo_reg[63:61]};
                        sched_reg[15] <= {len_lo_reg[60:0], 3'd0};
                        after_reg <= 1'b1;
                        fill_reg <= 7'd0;
                        round_reg <= 7'd0;
                        for (int i = 0; i < 8; i++) vars_reg[i] <= hash_reg[i];
                    end
                    else
                    begin
                        sched_reg[fill_reg[6:3]][8*(7-fill_reg[2:0]) +: 8] <=
                            padded_reg ? 8'd0 : PadByte;
                        padded_reg <= 1'b1;
                        fill_reg <= fill_reg + 7'd1;
                        if (full)
                        begin
                            round_reg <= 7'd0;
                            for (int i = 0; i < 8; i++) vars_reg[i] <= hash_reg[i];
                        end
                    end
                end
                ST_ROUNDS:
                begin
                    for (int i = 0; i < 8; i++) vars_reg[i] <= vars_out[i];
                    for (int i = 0; i < 15; i++) sched_reg[i] <= sched_reg[i+1];
                    sched_reg[15] <= w_out;
                    round_reg <= round_reg + 7'd1;
                end
                ST_FOLD:
                begin
                    for (int i = 0; i < 8; i++) hash_reg[i] <= hash_reg[i] + vars_reg[i];
                    idx_reg <= 3'd0;
                end
                ST_EMIT:
                if (out_acc)
                begin
                    idx_reg <= idx_reg + 3'd1;
                    if (last_word)
                    begin
                        len_lo_reg <= 64'd0;
                        len_hi_reg <= 64'd0;
                        fill_reg <= 7'd0;
                        for (int i = 0; i < 8; i++)
                            hash_reg[i] <= start_vector(variant_reg, 3'(i));
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== bench/sha512_family_hash_engine_test.sv =====
`timescale 1ns / 100ps
`default_nettype none

class digest_scoreboard;
    logic [63:0] hash_state [8];
    logic [63:0] block_buf [16];
    int unsigned fill;
    logic [127:0] byte_count;
    logic [1:0] variant;
    logic [63:0] pending_word [$];
    logic [2:0] pending_index [$];
    logic pending_last [$];
    int errors;
    int digests_seen;

    function void set_variant(logic [1:0] v);
        variant = v;
        restart();
    endfunction

    function logic [1:0] eff_variant();
        return (variant == sha512_pkg::VAR_SHA384 || variant == sha512_pkg::VAR_SHA512_256)
            ? variant : sha512_pkg::VAR_SHA512;
    endfunction

    function logic [63:0] iv_word(logic [1:0] v, int i);
        logic [63:0] iv512 [8];
        logic [63:0] iv384 [8];
        logic [63:0] iv256 [8];
        iv512 = '{64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B,
                  64'hA54FF53A5F1D36F1, 64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
                  64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179};
        iv384 = '{64'hCBBB9D5DC1059ED8, 64'h629A292A367CD507, 64'h9159015A3070DD17,
                  64'h152FECD8F70E5939, 64'h67332667FFC00B31, 64'h8EB44A8768581511,
                  64'hDB0C2E0D64F98FA7, 64'h47B5481DBEFA4FA4};
        iv256 = '{64'h22312194FC2BF72C, 64'h9F555FA3C84C64C2, 64'h2393B86B6F53B151,
                  64'h963877195940EABD, 64'h96283EE2A88EFFE3, 64'hBE5E1E2553863992,
                  64'h2B0199FC2C85B8AA, 64'h0EB72DDC81C52CA2};
        if (v == sha512_pkg::VAR_SHA384)
            return iv384[i];
        else if (v == sha512_pkg::VAR_SHA512_256)
            return iv256[i];
        return iv512[i];
    endfunction

    function void restart();
        for (int i = 0; i < 8; i++)
            hash_state[i] = iv_word(eff_variant(), i);
        fill = 0;
        byte_count = '0;
    endfunction

    function new();
        for (int i = 0; i < 16; i++)
            block_buf[i] = '0;
        errors = 0;
        digests_seen = 0;
        set_variant(sha512_pkg::VAR_SHA512);
    endfunction

    function logic [63:0] ror(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function logic [63:0] k_const(int i);
        logic [63:0] kt [80];
        kt = '{
            64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
            64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
            64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
            64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
            64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
            64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
            64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
            64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
            64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
            64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
            64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
            64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
            64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
            64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
            64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
            64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
            64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
            64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
            64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
            64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817};
        return kt[i];
    endfunction

    function void compress_block();
        logic [63:0] w [80];
        logic [63:0] v [8];
        logic [63:0] t1;
        logic [63:0] t2;
        for (int i = 0; i < 16; i++)
            w[i] = block_buf[i];
        for (int i = 16; i < 80; i++)
            w[i] = w[i-16] + (ror(w[i-15], 1) ^ ror(w[i-15], 8) ^ (w[i-15] >> 7))
                 + w[i-7] + (ror(w[i-2], 19) ^ ror(w[i-2], 61) ^ (w[i-2] >> 6));
        for (int i = 0; i < 8; i++)
            v[i] = hash_state[i];
        for (int i = 0; i < 80; i++)
        begin
            t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_const(i) + w[i];
            t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] += v[i];
    endfunction

    function void append_byte(logic [7:0] b);
        block_buf[fill >> 3][56 - 8 * (fill & 7) +: 8] = b;
        fill++;
        if (fill == 128)
        begin
            compress_block();
            fill = 0;
        end
    endfunction

    // note an accepted request and queue the digest words it produces
    function void note_request(logic [63:0] word, logic [3:0] nbytes, logic last);
        int nv;
        int n;
        logic [127:0] bits;
        nv = (nbytes > 8) ? 8 : nbytes;
        for (int k = 0; k < nv; k++)
            append_byte(word[56 - 8 * k +: 8]);
        byte_count += nv;
        if (!last)
            return;
        bits = byte_count << 3;
        append_byte(8'h80);
        if (fill > 112)
            while (fill != 0)
                append_byte(8'h00);
        while (fill < 112)
            append_byte(8'h00);
        block_buf[14] = bits[127:64];
        block_buf[15] = bits[63:0];
        compress_block();
        n = (eff_variant() == sha512_pkg::VAR_SHA384) ? 6 :
            (eff_variant() == sha512_pkg::VAR_SHA512_256) ? 4 : 8;
        for (int k = 0; k < n; k++)
        begin
            pending_word.push_back(hash_state[k]);
            pending_index.push_back(k[2:0]);
            pending_last.push_back(k == n - 1);
        end
        restart();
    endfunction

    function void check_digest(logic [63:0] word, logic [2:0] idx, logic last);
        if (pending_word.size() == 0)
        begin
            $display("%0t: unexpected digest word %h idx %0d", $time, word, idx);
            errors++;
            return;
        end
        if (word !== pending_word[0])
        begin
            $display("%0t: digest_word expected %h actual %h", $time, pending_word[0], word);
            errors++;
        end
        if (idx !== pending_index[0])
        begin
            $display("%0t: word_index expected %0d actual %0d", $time, pending_index[0], idx);
            errors++;
        end
        if (last !== pending_last[0])
        begin
            $display("%0t: last_word expected %0d actual %0d", $time, pending_last[0], last);
            errors++;
        end
        if (last === 1'b1)
            digests_seen++;
        void'(pending_word.pop_front());
        void'(pending_index.pop_front());
        void'(pending_last.pop_front());
    endfunction
endclass

module sha512_family_hash_engine_test;
    import sha512_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0;
    logic penable = 0;
    logic pwrite = 0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 0;
    logic in_stall;
    logic [63:0] message_word = '0;
    logic [3:0] valid_bytes = '0;
    logic last_in = 0;
    logic out_valid;
    logic out_stall = 0;
    logic [63:0] digest_word;
    logic [2:0] word_index;
    logic last_word;

    digest_scoreboard board;
    int idle_cycles = 0;
    int requests_sent = 0;
    bit long_hold = 0;
    bit sink_random = 1;

    localparam int IdleLimit = 20000;

    sha512_family_hash_engine uut (.*);

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall)
                board.check_digest(digest_word, word_index, last_word);
            if (idle_cycles >= IdleLimit)
            begin
                $display("timeout with %0d digest words pending", board.pending_word.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    // result side stall: random bursts, or a long hold when asked
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_stall <= 1;
                repeat (600) @(negedge clk);
                long_hold = 0;
            end
            if (sink_random && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 12);
                out_stall <= 1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 0;
        end
    end

    task automatic write_variant(logic [1:0] v);
        @(negedge clk);
        psel <= 1; pwrite <= 1; paddr <= 2'd0; pwdata <= {30'd0, v};
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        board.set_variant(v);
    endtask

    task automatic send_word(logic [63:0] w, logic [3:0] nb, logic last, bit gaps);
        int g;
        g = gaps ? (($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0) : 0;
        if (g > 0)
        begin
            in_valid <= 0;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1;
        message_word <= w;
        valid_bytes <= nb;
        last_in <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_request(w, nb, last);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic go_idle();
        in_valid <= 0;
        @(negedge clk);
    endtask

    task automatic drain();
        while (board.pending_word.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic send_message(int words, bit gaps);
        for (int i = 0; i < words - 1; i++)
            send_word(rand_word(),
                      ($urandom_range(0, 15) == 0) ? 4'($urandom_range(0, 15)) : 4'd8,
                      1'b0, gaps);
        send_word(rand_word(), 4'($urandom_range(0, 15)), 1'b1, gaps);
    endtask

    initial
    begin
        int len;
        board = new();
        repeat (2) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: empty message, three bytes, one full word from an oversize count, padding edges, odd counts
        send_word(64'h0, 4'd0, 1'b1, 0);
        send_word(64'h6162630000000000, 4'd3, 1'b1, 0);
        send_word(64'hFFFFFFFFFFFFFFFF, 4'd15, 1'b1, 0);
        for (int i = 0; i < 13; i++)
            send_word(64'hFFFFFFFFFFFFFFFF, 4'd8, 1'b0, 0);
        send_word(64'h0123456789ABCDEF, 4'd7, 1'b1, 0);
        send_word(64'hA5A5A5A5A5A5A5A5, 4'd5, 1'b0, 0);
        send_word(64'h5A5A5A5A5A5A5A5A, 4'd8, 1'b1, 0);
        go_idle();
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            write_variant((phase == 5) ? VAR_UNUSED : 2'(phase % 3));
            if (phase == 1)
            begin
                send_word(64'hDEADBEEF00000000, 4'd4, 1'b0, 0);
                go_idle();
                repeat (20) @(negedge clk);
                write_variant(VAR_SHA384);
            end
            if (phase == 2)
            begin
                long_hold = 1;
                for (int m = 0; m < 4; m++)
                    send_message(3, 0);
            end
            for (int m = 0; m < 15; m++)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 34) : $urandom_range(1, 5);
                send_message(len, 1);
            end
            go_idle();
            drain();
        end

        $display("%0d requests sent, %0d digests checked over all variants, stalls and pauses",
                 requests_sent, board.digests_seen);
        if (board.errors == 0 && board.pending_word.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
design/sha512_pkg.sv
design/sha512_round.sv
design/sha512_family_hash_engine.sv
bench/sha512_family_hash_engine_test.sv
